[hw/rtl/srg_pkg.sv]
// Shared types, constants and codes of the subtractive random generator.
package srg_pkg;

  // Lag table geometry
  localparam int unsigned TABLE_DEPTH = 56;
  localparam int unsigned ADDR_W      = 6;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [ADDR_W-1:0] LAG_FIRST    = 6'd1;
  localparam logic [ADDR_W-1:0] LAG_LAST     = 6'd55;
  localparam logic [ADDR_W-1:0] LAG_START    = 6'd21;
  localparam logic [ADDR_W-1:0] SCATTER_STEP = 6'd21;
  localparam logic [ADDR_W-1:0] SCATTER_LAST = 6'd54;
  localparam logic [ADDR_W-1:0] MIX_SPLIT    = 6'd24;
  localparam logic [ADDR_W-1:0] MIX_FWD      = 6'd31;
  localparam logic [1:0]        MIX_LAST_PASS = 2'd3;

  // Arithmetic constants
  localparam logic [DATA_W-1:0] LAG_M        = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] LAG_M_LESS   = 32'h7fff_fffe;
  localparam logic [DATA_W-1:0] MIN_INT      = 32'h8000_0000;
  localparam logic [DATA_W-1:0] LARGE_DIV    = 32'hffff_fffd;
  localparam logic [DATA_W:0]   LARGE_BIAS   = 33'd2147483646;
  localparam logic [DATA_W-2:0] RESET_OFFSET = 31'd161803398;

  // Divider sizing: three folds of the 64-bit product, then one compare and subtract
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned CNT_W  = 2;
  localparam logic [CNT_W-1:0] DIV_LAST = 2'd3;

  typedef enum logic [1:0] {
    ACT_RESEED = 2'd0,
    ACT_RAW    = 2'd1,
    ACT_BELOW  = 2'd2,
    ACT_RANGE  = 2'd3
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEED        = 2'd0,
    REG_SEED_OFFSET = 2'd1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_SCATTER,
    ST_MIX_RD,
    ST_MIX_WR,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_PREP,
    ST_SCALE,
    ST_PUSH
  } srg_state_e;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_ABS,
    SC_MUL,
    SC_DIV,
    SC_FIN
  } scale_state_e;

  // Channel payloads
  typedef struct packed {
    logic [1:0]               action;
    logic signed [DATA_W-1:0] lower_bound;
    logic signed [DATA_W-1:0] upper_bound;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;
  } cfg_item_t;

  // Lag table port bundle
  typedef struct packed {
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
  } mem_req_t;

  // Scaling request: result = addend + trunc(x * y / divisor)
  typedef struct packed {
    logic              wide;
    logic [DATA_W:0]   x;
    logic [DATA_W:0]   y;
    logic [DATA_W-1:0] addend;
  } scale_req_t;

endpackage

[hw/rtl/srg_chan_if.sv]
// Valid/ready channel carrying one payload beat.
interface srg_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/srg_lag_mem.sv]
// Lag table memory: one write port, two registered read ports.
module srg_lag_mem (
  input  logic                           clk_i,
  input  srg_pkg::mem_req_t              req_i,
  output logic [srg_pkg::DATA_W-1:0]     rd_data_a_o,
  output logic [srg_pkg::DATA_W-1:0]     rd_data_b_o
);

  logic [srg_pkg::DATA_W-1:0] mem_q [srg_pkg::TABLE_DEPTH];
  logic [srg_pkg::DATA_W-1:0] rd_a_q;
  logic [srg_pkg::DATA_W-1:0] rd_b_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  // Read two entries, registered
  always_ff @(posedge clk_i) begin
    rd_a_q <= mem_q[req_i.rd_addr_a];
    rd_b_q <= mem_q[req_i.rd_addr_b];
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

[hw/rtl/srg_scale.sv]
// Scaling unit: magnitude multiply, constant-divisor fold divide, signed offset.
module srg_scale (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  srg_pkg::scale_req_t         req_i,
  output logic                        done_o,
  output logic [srg_pkg::DATA_W-1:0]  value_o
);

  localparam int unsigned W  = srg_pkg::DATA_W;
  localparam int unsigned PW = srg_pkg::PROD_W;

  srg_pkg::scale_state_e state_q, state_d;
  logic [srg_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic done_q, done_d;

  logic          wide_q, wide_d;
  logic [W:0]    x_q, x_d;
  logic [W:0]    y_q, y_d;
  logic [W-1:0]  addend_q, addend_d;
  logic          neg_q, neg_d;
  logic [W-1:0]  magx_q, magx_d;
  logic [W-1:0]  magy_q, magy_d;
  logic [PW-1:0] rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  value_q, value_d;

  logic [W:0]    x_neg;
  logic [W:0]    y_neg;
  logic [W:0]    divisor;
  logic [W:0]    fold_hi;
  logic [W:0]    fold_lo;
  logic [W+2:0]  fold_sum;
  logic          take;

  // One fold: 2^31 is 1 mod M and 2^32 is 3 mod 2^32-3, so the high part moves
  // into the quotient and comes back into the remainder times 1 or 3
  always_comb begin
    x_neg   = (W+1)'(0) - x_q;
    y_neg   = (W+1)'(0) - y_q;
    divisor = {1'b0, (wide_q ? srg_pkg::LARGE_DIV : srg_pkg::LAG_M)};
    if (wide_q) begin
      fold_hi  = {1'b0, rem_q[PW-1:W]};
      fold_lo  = {1'b0, rem_q[W-1:0]};
      fold_sum = {1'b0, fold_hi, 1'b0} + {2'b00, fold_hi} + {2'b00, fold_lo};
    end else begin
      fold_hi  = rem_q[PW-1:W-1];
      fold_lo  = {2'b00, rem_q[W-2:0]};
      fold_sum = {2'b00, fold_hi} + {2'b00, fold_lo};
    end
    take = (rem_q[W:0] >= divisor);
  end

  // Sequence: latch, take magnitudes, multiply, divide, apply sign and offset
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    wide_d   = wide_q;
    x_d      = x_q;
    y_d      = y_q;
    addend_d = addend_q;
    neg_d    = neg_q;
    magx_d   = magx_q;
    magy_d   = magy_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    value_d  = value_q;
    case (state_q)
      srg_pkg::SC_IDLE: begin
        if (start_i) begin
          wide_d   = req_i.wide;
          x_d      = req_i.x;
          y_d      = req_i.y;
          addend_d = req_i.addend;
          state_d  = srg_pkg::SC_ABS;
        end
      end
      srg_pkg::SC_ABS: begin
        magx_d  = x_q[W] ? x_neg[W-1:0] : x_q[W-1:0];
        magy_d  = y_q[W] ? y_neg[W-1:0] : y_q[W-1:0];
        neg_d   = x_q[W] ^ y_q[W];
        state_d = srg_pkg::SC_MUL;
      end
      srg_pkg::SC_MUL: begin
        rem_d   = PW'(magx_q) * PW'(magy_q);
        quo_d   = '0;
        cnt_d   = '0;
        state_d = srg_pkg::SC_DIV;
      end
      srg_pkg::SC_DIV: begin
        cnt_d = cnt_q + srg_pkg::CNT_W'(1);
        if (cnt_q == srg_pkg::DIV_LAST) begin
          // Remainder now fits below twice the divisor: one compare and subtract
          quo_d   = quo_q + W'(take);
          state_d = srg_pkg::SC_FIN;
        end else begin
          rem_d = {{(PW-W-3){1'b0}}, fold_sum};
          quo_d = quo_q + fold_hi[W-1:0];
        end
      end
      srg_pkg::SC_FIN: begin
        value_d = neg_q ? (addend_q - quo_q) : (addend_q + quo_q);
        done_d  = 1'b1;
        state_d = srg_pkg::SC_IDLE;
      end
      default: begin
        state_d = srg_pkg::SC_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srg_pkg::SC_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    wide_q   <= wide_d;
    x_q      <= x_d;
    y_q      <= y_d;
    addend_q <= addend_d;
    neg_q    <= neg_d;
    magx_q   <= magx_d;
    magy_q   <= magy_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    value_q  <= value_d;
  end

  assign done_o  = done_q;
  assign value_o = value_q;

endmodule

[hw/rtl/subtractive_random_generator.sv]
// Subtractive random generator: sequencer, shared lag subtractor and channels.
//
// Lagged subtractive generator over a 56-entry table (entries 1..55 used), one
// request at a time. A raw draw (action 1) runs one table read, one subtract
// and write-back and one output load. Scaled draws (actions 2 and 3) add the
// scaling unit, which multiplies, folds the product three times against the
// constant divisor and finishes with one compare and subtract; a range that
// exceeds 2^31-1 draws two samples. A reseed (action 0) writes the table in 55
// single-entry steps and then runs four mixing passes of 55 read-modify-write
// steps, and returns a value of 0. Until the first reseed the table reads as all
// zeros and every sample drawn is 0. The result sits in an output register, so
// the next request is taken while the previous result waits. Configuration
// writes are always taken and should only be issued while the block is idle.
module subtractive_random_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  srg_chan_if.sink    in_chan_i,
  srg_chan_if.source  out_chan_o,
  srg_chan_if.sink    cfg_chan_i
);

  localparam int unsigned W = srg_pkg::DATA_W;
  localparam int unsigned A = srg_pkg::ADDR_W;

  // Control state
  srg_pkg::srg_state_e state_q, state_d;
  logic [A-1:0] idx_q, idx_d;
  logic [1:0]   pass_q, pass_d;
  logic [A-1:0] rd_idx_q, rd_idx_d;
  logic [A-1:0] lag_idx_q, lag_idx_d;
  logic         seeded_q, seeded_d;
  logic         second_q, second_d;
  logic         out_valid_q, out_valid_d;
  logic [W-1:0] seed_q, seed_d;
  logic [W-2:0] seed_offset_q, seed_offset_d;

  // Datapath state
  srg_pkg::action_e act_q, act_d;
  logic [W-1:0] lower_q, lower_d;
  logic [W-1:0] upper_q, upper_d;
  logic [W:0]   range_q, range_d;
  logic [W-1:0] samp_q, samp_d;
  logic [W-1:0] a_q, a_d;
  logic [W-1:0] mj_q, mj_d;
  logic [W-1:0] mk_q, mk_d;
  logic [A-1:0] ii_q, ii_d;
  logic [W-1:0] res_q, res_d;
  logic [W-1:0] out_value_q, out_value_d;

  // Memory and scaling unit hookup
  srg_pkg::mem_req_t   mem_req;
  logic [W-1:0]        rd_a;
  logic [W-1:0]        rd_b;
  logic [W-1:0]        ta;
  logic [W-1:0]        tb;
  srg_pkg::scale_req_t scale_req;
  logic                scale_start;
  logic                scale_done;
  logic [W-1:0]        scale_value;

  // Shared lag subtractor
  logic [W-1:0] lag_a;
  logic [W-1:0] lag_b;
  logic         lag_fix;
  logic [W-1:0] lag_diff;
  logic [W-1:0] lag_res;

  // Misc combinational values
  logic [A-1:0] rd_next;
  logic [A-1:0] lag_next;
  logic [A-1:0] mix_peer;
  logic [A:0]   ii_sum;
  logic [A-1:0] ii_next;
  logic [W-1:0] off_ext;
  logic [W-1:0] mj_init;
  logic [W:0]   a_ext;
  logic [W:0]   num;
  logic         range_large;

  srg_lag_mem u_mem (
    .clk_i       (clk_i),
    .req_i       (mem_req),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b)
  );

  srg_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scale_start),
    .req_i   (scale_req),
    .done_o  (scale_done),
    .value_o (scale_value)
  );

  // Table reads as zero until the first reseed
  assign ta = seeded_q ? rd_a : '0;
  assign tb = seeded_q ? rd_b : '0;

  // Pick subtractor operands
  always_comb begin
    lag_a   = ta;
    lag_b   = tb;
    lag_fix = 1'b0;
    case (state_q)
      srg_pkg::ST_SCATTER: begin
        lag_a = mj_q;
        lag_b = mk_q;
      end
      srg_pkg::ST_DRAW_WR: begin
        lag_fix = 1'b1;
      end
      default: begin
        lag_fix = 1'b0;
      end
    endcase
  end

  // Subtract, clip the modulus on draws, fold negatives back by adding M
  always_comb begin
    lag_diff = lag_a - lag_b;
    if (lag_fix && (lag_diff == srg_pkg::LAG_M)) begin
      lag_diff = srg_pkg::LAG_M_LESS;
    end
    lag_res = lag_diff[W-1] ? (lag_diff + srg_pkg::LAG_M) : lag_diff;
  end

  // Index arithmetic and seeding helpers
  always_comb begin
    rd_next  = (rd_idx_q == srg_pkg::LAG_LAST) ? srg_pkg::LAG_FIRST
                                               : rd_idx_q + srg_pkg::LAG_FIRST;
    lag_next = (lag_idx_q == srg_pkg::LAG_LAST) ? srg_pkg::LAG_FIRST
                                                : lag_idx_q + srg_pkg::LAG_FIRST;
    mix_peer = (idx_q <= srg_pkg::MIX_SPLIT) ? idx_q + srg_pkg::MIX_FWD
                                             : idx_q - srg_pkg::MIX_SPLIT;
    ii_sum   = {1'b0, ii_q} + {1'b0, srg_pkg::SCATTER_STEP};
    ii_next  = (ii_sum >= {1'b0, srg_pkg::LAG_LAST}) ?
               A'(ii_sum - {1'b0, srg_pkg::LAG_LAST}) : ii_sum[A-1:0];
    off_ext  = {1'b0, seed_offset_q};
    if (seed_q == srg_pkg::MIN_INT) begin
      mj_init = off_ext - srg_pkg::LAG_M;
    end else if (seed_q[W-1]) begin
      mj_init = off_ext + seed_q;
    end else begin
      mj_init = off_ext - seed_q;
    end
    // Wide range: bias plus the first sample, negated when the second is even
    a_ext = {a_q[W-1], a_q};
    if (!samp_q[0] && (a_q != srg_pkg::MIN_INT)) begin
      num = srg_pkg::LARGE_BIAS - a_ext;
    end else begin
      num = srg_pkg::LARGE_BIAS + a_ext;
    end
    range_large = !range_q[W] && range_q[W-1];
  end

  // Sequencer: next state and datapath control
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    pass_d        = pass_q;
    rd_idx_d      = rd_idx_q;
    lag_idx_d     = lag_idx_q;
    seeded_d      = seeded_q;
    second_d      = second_q;
    out_valid_d   = out_valid_q;
    seed_d        = seed_q;
    seed_offset_d = seed_offset_q;
    act_d         = act_q;
    lower_d       = lower_q;
    upper_d       = upper_q;
    range_d       = range_q;
    samp_d        = samp_q;
    a_d           = a_q;
    mj_d          = mj_q;
    mk_d          = mk_q;
    ii_d          = ii_q;
    res_d         = res_q;
    out_value_d   = out_value_q;

    mem_req           = '0;
    mem_req.rd_addr_a = idx_q;
    mem_req.rd_addr_b = mix_peer;
    scale_start       = 1'b0;
    scale_req.wide    = 1'b0;
    scale_req.x       = {samp_q[W-1], samp_q};
    scale_req.y       = {upper_q[W-1], upper_q};
    scale_req.addend  = '0;

    // Configuration beats
    if (cfg_chan_i.valid) begin
      case (cfg_chan_i.payload.index)
        srg_pkg::REG_SEED:        seed_d = cfg_chan_i.payload.data;
        srg_pkg::REG_SEED_OFFSET: seed_offset_d = cfg_chan_i.payload.data[W-2:0];
        default:                  seed_d = seed_q;
      endcase
    end

    // Drop the output beat once taken
    if (out_valid_q && out_chan_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      srg_pkg::ST_IDLE: begin
        if (in_chan_i.valid) begin
          act_d    = srg_pkg::action_e'(in_chan_i.payload.action);
          lower_d  = in_chan_i.payload.lower_bound;
          upper_d  = in_chan_i.payload.upper_bound;
          range_d  = {in_chan_i.payload.upper_bound[W-1], in_chan_i.payload.upper_bound}
                   - {in_chan_i.payload.lower_bound[W-1], in_chan_i.payload.lower_bound};
          second_d = 1'b0;
          state_d  = (srg_pkg::action_e'(in_chan_i.payload.action) == srg_pkg::ACT_RESEED)
                   ? srg_pkg::ST_SEED : srg_pkg::ST_DRAW_RD;
        end
      end
      srg_pkg::ST_SEED: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = srg_pkg::LAG_LAST;
        mem_req.wr_data = mj_init;
        mj_d      = mj_init;
        mk_d      = W'(1);
        ii_d      = srg_pkg::LAG_START;
        idx_d     = srg_pkg::LAG_FIRST;
        rd_idx_d  = '0;
        lag_idx_d = srg_pkg::LAG_START;
        seeded_d  = 1'b1;
        state_d   = srg_pkg::ST_SCATTER;
      end
      srg_pkg::ST_SCATTER: begin
        // Scatter the running difference over the table, 21 apart
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = ii_q;
        mem_req.wr_data = mk_q;
        mk_d = lag_res;
        mj_d = mk_q;
        ii_d = ii_next;
        if (idx_q == srg_pkg::SCATTER_LAST) begin
          idx_d   = srg_pkg::LAG_FIRST;
          pass_d  = '0;
          state_d = srg_pkg::ST_MIX_RD;
        end else begin
          idx_d = idx_q + srg_pkg::LAG_FIRST;
        end
      end
      srg_pkg::ST_MIX_RD: begin
        state_d = srg_pkg::ST_MIX_WR;
      end
      srg_pkg::ST_MIX_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = idx_q;
        mem_req.wr_data = lag_res;
        state_d = srg_pkg::ST_MIX_RD;
        if (idx_q == srg_pkg::LAG_LAST) begin
          idx_d  = srg_pkg::LAG_FIRST;
          pass_d = pass_q + 2'd1;
          if (pass_q == srg_pkg::MIX_LAST_PASS) begin
            res_d   = '0;
            state_d = srg_pkg::ST_PUSH;
          end
        end else begin
          idx_d = idx_q + srg_pkg::LAG_FIRST;
        end
      end
      srg_pkg::ST_DRAW_RD: begin
        mem_req.rd_addr_a = rd_next;
        mem_req.rd_addr_b = lag_next;
        rd_idx_d  = rd_next;
        lag_idx_d = lag_next;
        state_d   = srg_pkg::ST_DRAW_WR;
      end
      srg_pkg::ST_DRAW_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = rd_idx_q;
        mem_req.wr_data = lag_res;
        samp_d = lag_res;
        if (act_q == srg_pkg::ACT_RAW) begin
          res_d   = lag_res;
          state_d = srg_pkg::ST_PUSH;
        end else if ((act_q == srg_pkg::ACT_RANGE) && range_large && !second_q) begin
          a_d      = lag_res;
          second_d = 1'b1;
          state_d  = srg_pkg::ST_DRAW_RD;
        end else begin
          state_d = srg_pkg::ST_PREP;
        end
      end
      srg_pkg::ST_PREP: begin
        scale_start = 1'b1;
        if (act_q == srg_pkg::ACT_RANGE) begin
          scale_req.addend = lower_q;
          scale_req.y      = range_q;
          if (range_large) begin
            scale_req.wide = 1'b1;
            scale_req.x    = num;
          end
        end
        state_d = srg_pkg::ST_SCALE;
      end
      srg_pkg::ST_SCALE: begin
        if (scale_done) begin
          res_d   = scale_value;
          state_d = srg_pkg::ST_PUSH;
        end
      end
      srg_pkg::ST_PUSH: begin
        // Load the output register once it is free
        if (!out_valid_q || out_chan_o.ready) begin
          out_valid_d = 1'b1;
          out_value_d = res_q;
          state_d     = srg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = srg_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= srg_pkg::ST_IDLE;
      idx_q         <= '0;
      pass_q        <= '0;
      rd_idx_q      <= '0;
      lag_idx_q     <= srg_pkg::LAG_START;
      seeded_q      <= 1'b0;
      second_q      <= 1'b0;
      out_valid_q   <= 1'b0;
      seed_q        <= '0;
      seed_offset_q <= srg_pkg::RESET_OFFSET;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      pass_q        <= pass_d;
      rd_idx_q      <= rd_idx_d;
      lag_idx_q     <= lag_idx_d;
      seeded_q      <= seeded_d;
      second_q      <= second_d;
      out_valid_q   <= out_valid_d;
      seed_q        <= seed_d;
      seed_offset_q <= seed_offset_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    act_q       <= act_d;
    lower_q     <= lower_d;
    upper_q     <= upper_d;
    range_q     <= range_d;
    samp_q      <= samp_d;
    a_q         <= a_d;
    mj_q        <= mj_d;
    mk_q        <= mk_d;
    ii_q        <= ii_d;
    res_q       <= res_d;
    out_value_q <= out_value_d;
  end

  // Channel handshakes
  assign in_chan_i.ready           = (state_q == srg_pkg::ST_IDLE);
  assign cfg_chan_i.ready          = 1'b1;
  assign out_chan_o.valid          = out_valid_q;
  assign out_chan_o.payload.value  = out_value_q;

endmodule

[bench/tb.sv]
// Self-checking testbench for the subtractive random generator.
import srg_pkg::*;

// Predicts every result beat of the generator and checks the beats that come back.
class srg_scoreboard;
  logic [DATA_W-1:0]   lag_mem [TABLE_DEPTH];
  int unsigned         rd_idx;
  int unsigned         lag_idx;
  logic [DATA_W-1:0]   seed_reg;
  logic [DATA_W-2:0]   offset_reg;
  logic [DATA_W-1:0]   pending_values [$];
  int unsigned         errors;

  function new();
    foreach (lag_mem[i]) lag_mem[i] = '0;
    rd_idx     = 0;
    lag_idx    = LAG_START;
    seed_reg   = '0;
    offset_reg = RESET_OFFSET;
    errors     = 0;
  endfunction

  // Track a register write
  function void write_reg(cfg_reg_e idx, logic [DATA_W-1:0] data);
    if (idx == REG_SEED) begin
      seed_reg = data;
    end else if (idx == REG_SEED_OFFSET) begin
      offset_reg = data[DATA_W-2:0];
    end
  endfunction

  // Advance both lags, subtract, fold into [0, M-1] and write back
  function logic [DATA_W-1:0] draw_sample();
    logic [DATA_W-1:0] d;
    rd_idx  = (rd_idx + 1 >= TABLE_DEPTH) ? LAG_FIRST : rd_idx + 1;
    lag_idx = (lag_idx + 1 >= TABLE_DEPTH) ? LAG_FIRST : lag_idx + 1;
    d = lag_mem[rd_idx] - lag_mem[lag_idx];
    if (d == LAG_M) d = LAG_M_LESS;
    if (d[DATA_W-1]) d = d + LAG_M;
    lag_mem[rd_idx] = d;
    return d;
  endfunction

  // Scatter the seed over the table, then run four mixing passes
  function void reseed_table();
    logic [DATA_W-1:0] mag;
    logic [DATA_W-1:0] mj;
    logic [DATA_W-1:0] mk;
    int unsigned       ii;
    if (seed_reg == MIN_INT) begin
      mag = LAG_M;
    end else if (seed_reg[DATA_W-1]) begin
      mag = -seed_reg;
    end else begin
      mag = seed_reg;
    end
    mj = {1'b0, offset_reg} - mag;
    lag_mem[LAG_LAST] = mj;
    mk = 1;
    for (int i = 1; i < 55; i++) begin
      ii = (21 * i) % 55;
      lag_mem[ii] = mk;
      mk = mj - mk;
      if (mk[DATA_W-1]) mk = mk + LAG_M;
      mj = lag_mem[ii];
    end
    for (int k = 1; k < 5; k++) begin
      for (int i = 1; i < 56; i++) begin
        lag_mem[i] = lag_mem[i] - lag_mem[1 + (i + 30) % 55];
        if (lag_mem[i][DATA_W-1]) lag_mem[i] = lag_mem[i] + LAG_M;
      end
    end
    rd_idx  = 0;
    lag_idx = LAG_START;
  endfunction

  // Work out the value one request returns
  function logic [DATA_W-1:0] predict_value(in_item_t it);
    longint            s;
    longint            lo;
    longint            up;
    longint            rng;
    longint            num;
    longint            res;
    longint unsigned   mag;
    longint unsigned   rng_u;
    longint unsigned   q;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    lo  = $signed(it.lower_bound);
    up  = $signed(it.upper_bound);
    res = 0;
    case (action_e'(it.action))
      ACT_RESEED: begin
        reseed_table();
      end
      ACT_RAW: begin
        res = $signed(draw_sample());
      end
      ACT_BELOW: begin
        s   = $signed(draw_sample());
        res = s * up / longint'(LAG_M);
      end
      default: begin
        rng = up - lo;
        if (rng <= longint'(LAG_M)) begin
          s   = $signed(draw_sample());
          res = s * rng / longint'(LAG_M) + lo;
        end else begin
          // Wide range: the second sample's parity picks the sign of the first
          a = draw_sample();
          b = draw_sample();
          if (!b[0]) a = -a;
          num   = longint'($signed(a)) + longint'(LARGE_BIAS);
          mag   = (num < 0) ? -num : num;
          rng_u = rng;
          q     = mag * rng_u / {32'd0, LARGE_DIV};
          if (num < 0) begin
            res = -longint'(q) + lo;
          end else begin
            res = longint'(q) + lo;
          end
        end
      end
    endcase
    return res[DATA_W-1:0];
  endfunction

  // Queue the expectation for an accepted request beat
  function void note_request(in_item_t it);
    pending_values.push_back(predict_value(it));
  endfunction

  task report(string what);
    errors++;
    if (errors <= 100) $display("tb: mismatch: %s", what);
  endtask

  // Compare a result beat with the oldest expectation
  task check_result(out_item_t r);
    logic [DATA_W-1:0] want;
    if (pending_values.size() == 0) begin
      report($sformatf("unexpected result %0d", r.value));
    end else begin
      want = pending_values.pop_front();
      if (r.value !== want) begin
        report($sformatf("value %0d, expected %0d", r.value, $signed(want)));
      end
    end
  endtask
endclass

module tb;
  localparam int WATCH_LIMIT = 4000;
  localparam int LONG_HOLD   = 300;
  localparam int END_DRAIN   = 600;
  localparam int PHASE_ITEMS = 260;

  logic clk;
  logic rst_n;

  srg_chan_if #(.payload_t(in_item_t))  req_chan ();
  srg_chan_if #(.payload_t(out_item_t)) rsp_chan ();
  srg_chan_if #(.payload_t(cfg_item_t)) cfg_chan ();

  subtractive_random_generator dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_chan_i  (req_chan),
    .out_chan_o (rsp_chan),
    .cfg_chan_i (cfg_chan)
  );

  srg_scoreboard sb;
  int            quiet_cycles;
  int            rx_mode;
  bit            long_hold_req;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Watch all three channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_chan.valid && req_chan.ready) sb.note_request(req_chan.payload);
      if (cfg_chan.valid && cfg_chan.ready) begin
        sb.write_reg(cfg_reg_e'(cfg_chan.payload.index), cfg_chan.payload.data);
      end
      if (rsp_chan.valid && rsp_chan.ready) sb.check_result(rsp_chan.payload);
      if ((req_chan.valid && req_chan.ready) || (cfg_chan.valid && cfg_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("tb: watchdog expired, %0d results outstanding", sb.pending_values.size());
        $display("tb: errors");
        $finish;
      end
    end
  end

  // Drive result ready: long hold on request, otherwise the current stall pattern
  initial begin
    int run;
    bit level;
    run   = 0;
    level = 1'b1;
    rsp_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        rsp_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      case (rx_mode)
        0: rsp_chan.ready <= 1'b1;
        1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (run == 0) begin
            level = !level;
            run   = level ? $urandom_range(1, 6) : $urandom_range(1, 10);
          end
          run--;
          rsp_chan.ready <= level;
        end
      endcase
    end
  end

  function automatic logic [DATA_W-1:0] rand_bound();
    case ($urandom_range(0, 5))
      0: return MIN_INT;
      1: return LAG_M;
      2: return $urandom_range(0, 64) - 32;
      default: return $urandom();
    endcase
  endfunction

  function automatic in_item_t item_of(action_e act, logic [DATA_W-1:0] lo,
                                       logic [DATA_W-1:0] up);
    in_item_t it;
    it.action      = act;
    it.lower_bound = lo;
    it.upper_bound = up;
    return it;
  endfunction

  function automatic action_e pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return ACT_RESEED;
    case (r % 3)
      0: return ACT_RAW;
      1: return ACT_BELOW;
      default: return ACT_RANGE;
    endcase
  endfunction

  // Offer one request beat and hold it until taken
  task automatic send(in_item_t it);
    @(negedge clk);
    req_chan.valid   <= 1'b1;
    req_chan.payload <= it;
    do @(posedge clk); while (!req_chan.ready);
  endtask

  task automatic pause_req(int n);
    repeat (n) begin
      @(negedge clk);
      req_chan.valid <= 1'b0;
    end
  endtask

  task automatic write_cfg(cfg_reg_e idx, logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_chan.valid         <= 1'b1;
    cfg_chan.payload.index <= idx;
    cfg_chan.payload.data  <= data;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // Drop valid and wait for every expected result to come back
  task automatic wait_idle();
    pause_req(1);
    while (sb.pending_values.size() != 0) @(posedge clk);
  endtask

  // Random requests in bursts, with or without gaps between them
  task automatic run_random(int n, bit gaps);
    int sent;
    int burst;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < n; i++) begin
        send(item_of(pick_action(), rand_bound(), rand_bound()));
        sent++;
      end
      if (gaps) pause_req($urandom_range(1, 6));
    end
  endtask

  initial begin
    logic [DATA_W-1:0] seed_pick [6];
    logic [DATA_W-1:0] offset_pick [6];
    sb = new();
    quiet_cycles  = 0;
    rx_mode       = 0;
    long_hold_req = 1'b0;
    rst_n            = 1'b0;
    req_chan.valid   = 1'b0;
    req_chan.payload = '0;
    cfg_chan.valid   = 1'b0;
    cfg_chan.payload = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Draw from the zeroed table before any reseed
    send(item_of(ACT_RAW, '0, '0));
    send(item_of(ACT_BELOW, '0, LAG_M));
    send(item_of(ACT_RANGE, -32'sd5, 32'sd100));
    send(item_of(ACT_RANGE, MIN_INT, LAG_M));
    wait_idle();

    // Most negative seed, default offset, then cover bounds and all actions
    write_cfg(REG_SEED, MIN_INT);
    write_cfg(REG_SEED_OFFSET, RESET_OFFSET);
    send(item_of(ACT_RESEED, '0, '0));
    send(item_of(ACT_RAW, '0, '0));
    send(item_of(ACT_RAW, MIN_INT, MIN_INT));
    send(item_of(ACT_BELOW, '0, LAG_M));
    send(item_of(ACT_BELOW, '0, MIN_INT));
    send(item_of(ACT_BELOW, '0, '0));
    send(item_of(ACT_BELOW, '0, '1));
    send(item_of(ACT_BELOW, '0, 32'd1));
    send(item_of(ACT_RANGE, MIN_INT, LAG_M));
    send(item_of(ACT_RANGE, '0, LAG_M));
    send(item_of(ACT_RANGE, '1, LAG_M));
    send(item_of(ACT_RANGE, LAG_M, MIN_INT));
    send(item_of(ACT_RANGE, 32'd5, 32'd5));
    send(item_of(ACT_RANGE, LAG_M - 32'd10, LAG_M));
    send(item_of(ACT_RANGE, MIN_INT, MIN_INT + 32'd1));
    send(item_of(ACT_RANGE, LAG_M, LAG_M + 32'd1000));
    send(item_of(ACT_RESEED, '1, '1));
    send(item_of(ACT_RAW, '1, '1));
    wait_idle();

    // Hold results off for a long stretch while requests keep coming
    rx_mode       = 1;
    long_hold_req = 1'b1;
    for (int i = 0; i < 24; i++) send(item_of(ACT_RAW, rand_bound(), rand_bound()));
    wait_idle();

    // Random phases over several register settings
    seed_pick   = '{32'd0, 32'd1, '1, LAG_M, $urandom(), $urandom()};
    offset_pick = '{32'd0, LAG_M, RESET_OFFSET, $urandom(), 32'd1, $urandom()};
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_cfg(REG_SEED, seed_pick[p]);
      if (p != 3) write_cfg(REG_SEED_OFFSET, offset_pick[p]);
      rx_mode = p % 3;
      if (p == 4) long_hold_req = 1'b1;
      if (p != 5) send(item_of(ACT_RESEED, rand_bound(), rand_bound()));
      run_random(PHASE_ITEMS, p != 1);
    end

    wait_idle();
    repeat (END_DRAIN) @(posedge clk);
    if (sb.pending_values.size() != 0) sb.report("results still outstanding at end");
    if (sb.errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
